### src/sio_pkg.sv
// Shared types and register offsets for the switched I/O register block.
// No dependencies.
`default_nettype none

package sio_pkg;

	typedef enum logic [0:0] {
		OP_READ  = 1'b0,
		OP_WRITE = 1'b1
	} op_t;

	localparam logic [3:0] OFF_SELECT   = 4'd0;
	localparam logic [3:0] OFF_RAM_ADDR = 4'd1;
	localparam logic [3:0] OFF_RAM_DATA = 4'd2;
	localparam logic [3:0] OFF_COLOR    = 4'd6;
	localparam logic [3:0] OFF_PATTERN  = 4'd7;

	localparam logic [7:0] IDLE_BYTE = 8'hff;
	localparam int RAM_DEPTH = 16;

	typedef struct packed {
		op_t        op;
		logic [3:0] offset;
		logic [7:0] data;
	} access_t;

endpackage

`default_nettype wire

### src/sio_regs.sv
// Register file of the switched I/O block: select flag, backup RAM, color and pattern.
// Depends on sio_pkg.
`default_nettype none

module sio_regs #(
	parameter logic [7:0] DEVICE_ID = 8'd254
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire sio_pkg::access_t acc,
	output logic [7:0]            rdata,
	output logic                  selected
);

	logic       selected_q;
	logic [3:0] ram_addr_q;
	logic [7:0] ram_q [sio_pkg::RAM_DEPTH];
	logic [7:0] color_new_q;
	logic [7:0] color_prev_q;
	logic [7:0] pattern_q;

	logic is_write;
	assign is_write = (acc.op == sio_pkg::OP_WRITE);
	assign selected = selected_q;

	// Read data path
	always_comb begin
		rdata = sio_pkg::IDLE_BYTE;
		if (!is_write && selected_q) begin
			unique case (acc.offset)
				sio_pkg::OFF_SELECT:   rdata = DEVICE_ID ^ 8'hff;
				sio_pkg::OFF_RAM_DATA: rdata = ram_q[ram_addr_q];
				sio_pkg::OFF_PATTERN:  rdata = pattern_q[7] ? color_prev_q : color_new_q;
				default:               rdata = sio_pkg::IDLE_BYTE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			selected_q   <= 1'b0;
			ram_addr_q   <= 4'd0;
			color_new_q  <= 8'd0;
			color_prev_q <= 8'd0;
			pattern_q    <= 8'd0;
			for (int i = 0; i < sio_pkg::RAM_DEPTH; i++) begin
				ram_q[i] <= sio_pkg::IDLE_BYTE;
			end
		end else if (fire) begin
			if (is_write) begin
				if (acc.offset == sio_pkg::OFF_SELECT) begin
					selected_q <= (acc.data == DEVICE_ID);
				end else if (selected_q) begin
					unique case (acc.offset)
						sio_pkg::OFF_RAM_ADDR: ram_addr_q <= acc.data[3:0];
						sio_pkg::OFF_RAM_DATA: ram_q[ram_addr_q] <= acc.data;
						sio_pkg::OFF_COLOR: begin
							color_prev_q <= color_new_q;
							color_new_q  <= acc.data;
						end
						sio_pkg::OFF_PATTERN:  pattern_q <= acc.data;
						default: ;
					endcase
				end
			end else if (selected_q && acc.offset == sio_pkg::OFF_PATTERN) begin
				// rotate left after the color is picked
				pattern_q <= {pattern_q[6:0], pattern_q[7]};
			end
		end
	end

endmodule

`default_nettype wire

### src/switched_io_backup_ram_pattern_regs.sv
// Top level of the switched I/O register block: request register, register file, result register.
// Depends on sio_pkg and sio_regs.
`default_nettype none

// Switched I/O register block. Each request is one bus read or write at a 4-bit
// offset and yields exactly one result byte (0xff for writes). Writing DEVICE_ID at
// offset 0 selects the block, any other value deselects it. While selected, offset 0
// reads the inverted ID, offset 1 latches a 4-bit backup RAM address, offset 2 reads
// or writes that RAM byte (all 0xff after reset, no clearing pass needed), offset 6
// shifts a pair of color registers, and offset 7 holds a pattern whose top bit picks
// the color returned on read before the pattern rotates left. Timing: a request is
// registered on acceptance, then decoded and applied to the registers once the result
// register is free or draining, and its result is registered then; the block takes one
// request per cycle sustained; the only stall comes from out_ready being held low.

module switched_io_backup_ram_pattern_regs #(
	parameter logic [7:0] DEVICE_ID = 8'd254
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       operation,
	input  wire logic [3:0] register_offset,
	input  wire logic [7:0] write_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      read_data
);

	logic             valid_s1;
	sio_pkg::access_t acc_s1;
	logic             advance;
	logic [7:0]       rdata;
	logic             selected;
	logic             out_valid_q;
	logic [7:0]       read_data_q;

	// Advance the decode stage whenever the result register is free or draining.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			acc_s1.op     <= sio_pkg::op_t'(operation);
			acc_s1.offset <= register_offset;
			acc_s1.data   <= write_data;
		end
	end

	// Registers change only when the request moves on, so each request acts once.
	sio_regs #(
		.DEVICE_ID(DEVICE_ID)
	) u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (advance),
		.acc      (acc_s1),
		.rdata    (rdata),
		.selected (selected)
	);

	// Result register: hold while stalled, drop after it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q <= rdata;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

	// Input is held off only while a request sits in the decode stage.
	a_ready_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1)
		else $error("in_ready low with empty decode stage");

	// A write of the device ID at offset 0 leaves the block selected.
	a_select_write: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && acc_s1.op == sio_pkg::OP_WRITE && acc_s1.offset == sio_pkg::OFF_SELECT
			&& acc_s1.data == DEVICE_ID) |=> selected)
		else $error("select write did not select the block");

	// A read while deselected, or any write, returns the idle byte.
	a_idle_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (acc_s1.op == sio_pkg::OP_WRITE || !selected))
			|=> (out_valid && read_data == sio_pkg::IDLE_BYTE))
		else $error("write or deselected read returned a non-idle byte");

endmodule

`default_nettype wire
